// ===== rtl/nnsb_pkg.sv =====
// ============================================================================
// nnsb_pkg
// Shared types and constants for the nearest-neighbor scale blit.
// ============================================================================
package nnsb_pkg;

    localparam int POS_W  = 12;
    localparam int CH_W   = 8;
    localparam int CFG_DW = 13;
    localparam int REL_W  = POS_W + 2;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_COMP = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        CFG_SRC_W    = 3'd0,
        CFG_SRC_H    = 3'd1,
        CFG_CANVAS_C = 3'd2,
        CFG_CANVAS_R = 3'd3,
        CFG_TGT_W    = 3'd4,
        CFG_TGT_H    = 3'd5,
        CFG_OFF_X    = 3'd6,
        CFG_OFF_Y    = 3'd7
    } t_cfg_idx;

    localparam logic [8:0]        RST_SRC_W    = 9'd256;
    localparam logic [8:0]        RST_SRC_H    = 9'd256;
    localparam logic [POS_W-1:0]  RST_CANVAS_C = 12'd640;
    localparam logic [POS_W-1:0]  RST_CANVAS_R = 12'd480;
    localparam logic [POS_W-1:0]  RST_TGT_W    = 12'd640;
    localparam logic [POS_W-1:0]  RST_TGT_H    = 12'd480;
    localparam logic [CFG_DW-1:0] RST_OFF      = 13'd0;

    typedef struct packed {
        t_req             req_type;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [CH_W-1:0]  in_red;
        logic [CH_W-1:0]  in_green;
        logic [CH_W-1:0]  in_blue;
        logic [CH_W-1:0]  in_alpha;
    } t_in_beat;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic            covered;
    } t_out_beat;

    typedef struct packed {
        logic [8:0]               src_w;
        logic [8:0]               src_h;
        logic [POS_W-1:0]         canvas_c;
        logic [POS_W-1:0]         canvas_r;
        logic [POS_W-1:0]         tgt_w;
        logic [POS_W-1:0]         tgt_h;
        logic signed [CFG_DW-1:0] off_x;
        logic signed [CFG_DW-1:0] off_y;
    } t_cfg;

    typedef struct packed {
        logic             vld;
        t_req             req;
        logic             wr_ok;
        logic             hit;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_meta;

endpackage

// ===== rtl/nnsb_stream_if.sv =====
// ============================================================================
// nnsb_stream_if
// Valid/ready stream channel carrying one payload beat.
// ============================================================================
interface nnsb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/nnsb_ram.sv =====
// ============================================================================
// nnsb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module nnsb_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                              i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                              o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/nnsb_front.sv =====
// ============================================================================
// nnsb_front
// Offset, clipping and scale-product stages for both axes.
// ============================================================================
module nnsb_front #(
    parameter int MAX_SRC_W = 256,
    parameter int MAX_SRC_H = 256,
    parameter int SB        = 9,
    parameter int PW        = 21
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  nnsb_pkg::t_in_beat  i_beat,
    input  nnsb_pkg::t_cfg      i_cfg,
    input  logic [SB-1:0]       i_src_w,
    input  logic [SB-1:0]       i_src_h,
    output nnsb_pkg::t_meta     o_meta,
    output logic [PW-1:0]       o_prod_x,
    output logic [PW-1:0]       o_prod_y
);
    nnsb_pkg::t_meta                   n_m1;
    nnsb_pkg::t_meta                   r_m1;
    nnsb_pkg::t_meta                   n_m2;
    nnsb_pkg::t_meta                   r_m2;
    logic [nnsb_pkg::REL_W-1:0]        n_rel_x;
    logic [nnsb_pkg::REL_W-1:0]        n_rel_y;
    logic [nnsb_pkg::REL_W-1:0]        r_rel_x;
    logic [nnsb_pkg::REL_W-1:0]        r_rel_y;
    logic                              w_hit_x;
    logic                              w_hit_y;
    logic [PW-1:0]                     r_prod_x;
    logic [PW-1:0]                     r_prod_y;

    always_comb begin
        n_m1.vld   = i_vld;
        n_m1.req   = i_beat.req_type;
        n_m1.wr_ok = (int'(i_beat.pos_x) < MAX_SRC_W) && (int'(i_beat.pos_y) < MAX_SRC_H);
        n_m1.hit   = (i_beat.pos_x < i_cfg.canvas_c) && (i_beat.pos_y < i_cfg.canvas_r);
        n_m1.red   = i_beat.in_red;
        n_m1.green = i_beat.in_green;
        n_m1.blue  = i_beat.in_blue;
        n_m1.alpha = i_beat.in_alpha;
        n_m1.pos_x = i_beat.pos_x;
        n_m1.pos_y = i_beat.pos_y;
        n_rel_x = {2'b00, i_beat.pos_x} - {i_cfg.off_x[nnsb_pkg::CFG_DW-1], i_cfg.off_x};
        n_rel_y = {2'b00, i_beat.pos_y} - {i_cfg.off_y[nnsb_pkg::CFG_DW-1], i_cfg.off_y};
    end

    assign w_hit_x = !r_rel_x[nnsb_pkg::REL_W-1] &&
                     (r_rel_x[nnsb_pkg::REL_W-2:0] < {1'b0, i_cfg.tgt_w});
    assign w_hit_y = !r_rel_y[nnsb_pkg::REL_W-1] &&
                     (r_rel_y[nnsb_pkg::REL_W-2:0] < {1'b0, i_cfg.tgt_h});

    always_comb begin
        n_m2     = r_m1;
        n_m2.hit = r_m1.hit && w_hit_x && w_hit_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1 <= '0;
            r_m2 <= '0;
        end else if (i_en) begin
            r_m1 <= n_m1;
            r_m2 <= n_m2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rel_x  <= n_rel_x;
            r_rel_y  <= n_rel_y;
            r_prod_x <= PW'(r_rel_x[nnsb_pkg::POS_W-1:0]) * PW'(i_src_w);
            r_prod_y <= PW'(r_rel_y[nnsb_pkg::POS_W-1:0]) * PW'(i_src_h);
        end
    end

    assign o_meta   = r_m2;
    assign o_prod_x = r_prod_x;
    assign o_prod_y = r_prod_y;
endmodule

// ===== rtl/nnsb_div.sv =====
// ============================================================================
// nnsb_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module nnsb_div #(
    parameter int QW = 8,
    parameter int PW = 21
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [PW-1:0]              i_dividend,
    input  logic [nnsb_pkg::POS_W-1:0] i_divisor,
    output logic [QW-1:0]              o_quot
);
    logic [PW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quot [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [PW-1:0] w_prev;
        logic [QW-1:0] w_pq;
        logic [PW-1:0] w_dsh;
        logic          w_ge;
        logic [PW-1:0] n_rem;
        logic [QW-1:0] n_quot;

        if (k == 0) begin : g_first
            assign w_prev = i_dividend;
            assign w_pq   = '0;
        end else begin : g_next
            assign w_prev = r_rem[k-1];
            assign w_pq   = r_quot[k-1];
        end

        assign w_dsh = PW'(i_divisor) << (QW - 1 - k);
        assign w_ge  = w_prev >= w_dsh;

        always_comb begin
            n_rem  = w_ge ? (w_prev - w_dsh) : w_prev;
            n_quot = w_pq;
            n_quot[QW-1-k] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quot[k] <= n_quot;
            end
        end
    end

    assign o_quot = r_quot[QW-1];
endmodule

// ===== rtl/nnsb_fetch.sv =====
// ============================================================================
// nnsb_fetch
// Frame store address, store access, result select and output buffer.
// ============================================================================
module nnsb_fetch #(
    parameter int MAX_SRC_W = 256,
    parameter int MAX_SRC_H = 256,
    parameter int QW        = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  nnsb_pkg::t_meta i_meta,
    input  logic [QW-1:0]   i_quot_x,
    input  logic [QW-1:0]   i_quot_y,
    output logic            o_full,
    nnsb_stream_if.source   o_out
);
    localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PIX_W = 3 * nnsb_pkg::CH_W;

    logic [nnsb_pkg::POS_W-1:0] w_row;
    logic [nnsb_pkg::POS_W-1:0] w_col;
    logic [AW-1:0]              n_addr;
    logic [AW-1:0]              r_addr;
    nnsb_pkg::t_meta            r_ma;
    nnsb_pkg::t_meta            r_mb;
    logic                       w_we;
    logic [PIX_W-1:0]           w_rdata;
    nnsb_pkg::t_out_beat        w_res;
    nnsb_pkg::t_out_beat        r_s0;
    nnsb_pkg::t_out_beat        r_s1;
    logic [1:0]                 r_cnt;
    logic                       w_push;
    logic                       w_pop;

    always_comb begin
        if (i_meta.req == nnsb_pkg::REQ_LOAD) begin
            w_row = i_meta.pos_y;
            w_col = i_meta.pos_x;
        end else begin
            w_row = nnsb_pkg::POS_W'(i_quot_y);
            w_col = nnsb_pkg::POS_W'(i_quot_x);
        end
        n_addr = AW'(w_row) * AW'(MAX_SRC_W) + AW'(w_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma <= '0;
            r_mb <= '0;
        end else if (i_en) begin
            r_ma <= i_meta;
            r_mb <= r_ma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_addr <= n_addr;
        end
    end

    assign w_we = i_en && r_ma.vld && (r_ma.req == nnsb_pkg::REQ_LOAD) && r_ma.wr_ok;

    nnsb_ram #(
        .W     (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata ({r_ma.red, r_ma.green, r_ma.blue}),
        .i_re    (i_en),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_mb.hit) begin
            w_res.out_red   = w_rdata[PIX_W-1 -: nnsb_pkg::CH_W];
            w_res.out_green = w_rdata[nnsb_pkg::CH_W +: nnsb_pkg::CH_W];
            w_res.out_blue  = w_rdata[0 +: nnsb_pkg::CH_W];
            w_res.out_alpha = nnsb_pkg::ALPHA_OPAQUE;
            w_res.covered   = 1'b1;
        end else begin
            w_res.out_red   = r_mb.red;
            w_res.out_green = r_mb.green;
            w_res.out_blue  = r_mb.blue;
            w_res.out_alpha = r_mb.alpha;
            w_res.covered   = 1'b0;
        end
    end

    assign w_push = i_en && r_mb.vld && (r_mb.req == nnsb_pkg::REQ_COMP);
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_push && !w_pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (w_push && w_pop) begin
            if (r_cnt == 2'd2) begin
                r_s0 <= r_s1;
                r_s1 <= w_res;
            end else begin
                r_s0 <= w_res;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_s0 <= w_res;
            end else begin
                r_s1 <= w_res;
            end
        end else if (w_pop) begin
            r_s0 <= r_s1;
        end
    end

    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.data  = r_s0;
    assign o_full      = (r_cnt == 2'd2);
endmodule

// ===== rtl/nearest_neighbor_scale_blit.sv =====
// ============================================================================
// nearest_neighbor_scale_blit
// Pipeline depth is set by the divider, one quotient bit per stage, with QW
//   quotient bits, where QW is clog2 of the larger source limit.
// Throughput: one beat per cycle; input stalls only while the two-entry
//   output buffer is full. Loads produce no result beat.
// Reset: synchronous, active low; clears valid bits and the output buffer and
//   returns the configuration registers to their defaults. The frame store is
//   not cleared.
// ============================================================================
module nearest_neighbor_scale_blit #(
    parameter int MAX_SRC_W = 256,
    parameter int MAX_SRC_H = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [$bits(nnsb_pkg::t_cfg_idx)-1:0]  i_cfg_idx,
    input  logic [nnsb_pkg::CFG_DW-1:0]            i_cfg_data,
    nnsb_stream_if.sink                            i_in,
    nnsb_stream_if.source                          o_out
);
    localparam int SWB = $clog2(MAX_SRC_W + 1);
    localparam int SHB = $clog2(MAX_SRC_H + 1);
    localparam int SB  = (SWB > SHB) ? SWB : SHB;
    localparam int QWX = (MAX_SRC_W > 1) ? $clog2(MAX_SRC_W) : 1;
    localparam int QWY = (MAX_SRC_H > 1) ? $clog2(MAX_SRC_H) : 1;
    localparam int QW  = (QWX > QWY) ? QWX : QWY;
    localparam int PW  = nnsb_pkg::POS_W + SB;

    nnsb_pkg::t_cfg  r_cfg;
    logic [SB-1:0]   w_src_w;
    logic [SB-1:0]   w_src_h;
    logic            w_adv;
    logic            w_full;
    nnsb_pkg::t_meta w_meta2;
    nnsb_pkg::t_meta r_meta_d [QW];
    logic [PW-1:0]   w_prod_x;
    logic [PW-1:0]   w_prod_y;
    logic [QW-1:0]   w_quot_x;
    logic [QW-1:0]   w_quot_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w    <= nnsb_pkg::RST_SRC_W;
            r_cfg.src_h    <= nnsb_pkg::RST_SRC_H;
            r_cfg.canvas_c <= nnsb_pkg::RST_CANVAS_C;
            r_cfg.canvas_r <= nnsb_pkg::RST_CANVAS_R;
            r_cfg.tgt_w    <= nnsb_pkg::RST_TGT_W;
            r_cfg.tgt_h    <= nnsb_pkg::RST_TGT_H;
            r_cfg.off_x    <= nnsb_pkg::RST_OFF;
            r_cfg.off_y    <= nnsb_pkg::RST_OFF;
        end else if (i_cfg_we) begin
            unique case (nnsb_pkg::t_cfg_idx'(i_cfg_idx))
                nnsb_pkg::CFG_SRC_W:    r_cfg.src_w    <= i_cfg_data[8:0];
                nnsb_pkg::CFG_SRC_H:    r_cfg.src_h    <= i_cfg_data[8:0];
                nnsb_pkg::CFG_CANVAS_C: r_cfg.canvas_c <= i_cfg_data[nnsb_pkg::POS_W-1:0];
                nnsb_pkg::CFG_CANVAS_R: r_cfg.canvas_r <= i_cfg_data[nnsb_pkg::POS_W-1:0];
                nnsb_pkg::CFG_TGT_W:    r_cfg.tgt_w    <= i_cfg_data[nnsb_pkg::POS_W-1:0];
                nnsb_pkg::CFG_TGT_H:    r_cfg.tgt_h    <= i_cfg_data[nnsb_pkg::POS_W-1:0];
                nnsb_pkg::CFG_OFF_X:    r_cfg.off_x    <= i_cfg_data;
                nnsb_pkg::CFG_OFF_Y:    r_cfg.off_y    <= i_cfg_data;
                default:                r_cfg          <= r_cfg;
            endcase
        end
    end

    // clamp source size to 1..limit
    always_comb begin
        if (r_cfg.src_w == 9'd0) begin
            w_src_w = SB'(1);
        end else if (int'(r_cfg.src_w) > MAX_SRC_W) begin
            w_src_w = SB'(MAX_SRC_W);
        end else begin
            w_src_w = SB'(r_cfg.src_w);
        end
        if (r_cfg.src_h == 9'd0) begin
            w_src_h = SB'(1);
        end else if (int'(r_cfg.src_h) > MAX_SRC_H) begin
            w_src_h = SB'(MAX_SRC_H);
        end else begin
            w_src_h = SB'(r_cfg.src_h);
        end
    end

    assign w_adv      = !w_full;
    assign i_in.ready = w_adv;

    nnsb_front #(
        .MAX_SRC_W (MAX_SRC_W),
        .MAX_SRC_H (MAX_SRC_H),
        .SB        (SB),
        .PW        (PW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_vld    (i_in.valid),
        .i_beat   (i_in.data),
        .i_cfg    (r_cfg),
        .i_src_w  (w_src_w),
        .i_src_h  (w_src_h),
        .o_meta   (w_meta2),
        .o_prod_x (w_prod_x),
        .o_prod_y (w_prod_y)
    );

    nnsb_div #(
        .QW (QW),
        .PW (PW)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend (w_prod_x),
        .i_divisor  (r_cfg.tgt_w),
        .o_quot     (w_quot_x)
    );

    nnsb_div #(
        .QW (QW),
        .PW (PW)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend (w_prod_y),
        .i_divisor  (r_cfg.tgt_h),
        .o_quot     (w_quot_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_meta_d[k] <= '0;
            end
        end else if (w_adv) begin
            r_meta_d[0] <= w_meta2;
            for (int k = 1; k < QW; k++) begin
                r_meta_d[k] <= r_meta_d[k-1];
            end
        end
    end

    nnsb_fetch #(
        .MAX_SRC_W (MAX_SRC_W),
        .MAX_SRC_H (MAX_SRC_H),
        .QW        (QW)
    ) u_fetch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_meta   (r_meta_d[QW-1]),
        .i_quot_x (w_quot_x),
        .i_quot_y (w_quot_y),
        .o_full   (w_full),
        .o_out    (o_out)
    );
endmodule

// ===== rtl/nnsb_chk.sv =====
// ============================================================================
// nnsb_chk
// Port-level checks for the scale blit, bound to the top level.
// ============================================================================
module nnsb_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_covered,
    input logic [nnsb_pkg::CH_W-1:0] i_out_alpha
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped before it was taken");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    a_cover_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_covered |-> i_out_alpha == nnsb_pkg::ALPHA_OPAQUE)
        else $error("covered pixel not opaque");

    a_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> i_in_ready)
        else $error("input not ready after a result beat was taken");
endmodule

bind nearest_neighbor_scale_blit nnsb_chk u_nnsb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_covered (o_out.data.covered),
    .i_out_alpha   (o_out.data.out_alpha)
);

// ===== tb/nearest_neighbor_scale_blit_tb.sv =====
// ============================================================================
// nearest_neighbor_scale_blit_tb
// Streams source loads and canvas composites through the scale blit under
// several register settings, predicts each composited pixel from a local copy
// of the frame store and the registers, and compares every result beat.
// ============================================================================
module nearest_neighbor_scale_blit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SRC_W_MAX   = 256;
    localparam int SRC_H_MAX   = 256;
    localparam int ITEM_GOAL   = 1450;
    localparam int DRAIN_PAD   = 24;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_CAP   = 60;
    localparam int POS_W       = nnsb_pkg::POS_W;
    localparam int CFG_DW      = nnsb_pkg::CFG_DW;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [2:0]             i_cfg_idx;
    logic [CFG_DW-1:0]      i_cfg_data;

    nnsb_stream_if #(.T(nnsb_pkg::t_in_beat))  in_if ();
    nnsb_stream_if #(.T(nnsb_pkg::t_out_beat)) out_if ();

    nearest_neighbor_scale_blit #(
        .MAX_SRC_W (SRC_W_MAX),
        .MAX_SRC_H (SRC_H_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    nnsb_pkg::t_cfg      blit_cfg;
    logic [23:0]         src_pix    [SRC_W_MAX*SRC_H_MAX];
    bit                  src_loaded [SRC_W_MAX*SRC_H_MAX];
    nnsb_pkg::t_out_beat pixel_q [$];
    int                  mismatches;
    int                  beats_sent;
    int                  cycle_count;
    int                  stall_left;
    bit                  sink_steady;
    bit                  source_steady;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        return ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
    endfunction

    function automatic int unsigned clamp_src(input logic [8:0] v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic bit map_axis(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] extent,
                                    input logic signed [CFG_DW-1:0] off,
                                    input logic [POS_W-1:0] dst, input int unsigned src,
                                    output int unsigned idx);
        int p;
        int o;
        int rel;
        int unsigned s;
        idx = 0;
        if (extent == 0 || dst == 0 || pos >= extent) return 0;
        p   = pos;
        o   = off;
        rel = p - o;
        if (rel < 0 || rel >= int'(dst)) return 0;
        s = (int'(rel) * src) / dst;
        if (s > src - 1) s = src - 1;
        idx = s;
        return 1;
    endfunction

    function automatic bit locate_source(input nnsb_pkg::t_in_beat beat,
                                         output int unsigned addr);
        int unsigned sx;
        int unsigned sy;
        bit hx;
        bit hy;
        hx = map_axis(beat.pos_x, blit_cfg.canvas_c, blit_cfg.off_x, blit_cfg.tgt_w,
                      clamp_src(blit_cfg.src_w, SRC_W_MAX), sx);
        hy = map_axis(beat.pos_y, blit_cfg.canvas_r, blit_cfg.off_y, blit_cfg.tgt_h,
                      clamp_src(blit_cfg.src_h, SRC_H_MAX), sy);
        addr = sy * SRC_W_MAX + sx;
        return hx && hy;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string fld, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", fld, got, want));
    endtask

    task automatic record_beat(input nnsb_pkg::t_in_beat beat);
        nnsb_pkg::t_out_beat want;
        int unsigned         addr;
        if (beat.req_type == nnsb_pkg::REQ_LOAD) begin
            if (beat.pos_x < SRC_W_MAX && beat.pos_y < SRC_H_MAX) begin
                addr             = beat.pos_y * SRC_W_MAX + beat.pos_x;
                src_pix[addr]    = {beat.in_red, beat.in_green, beat.in_blue};
                src_loaded[addr] = 1'b1;
            end
        end else begin
            if (locate_source(beat, addr)) begin
                {want.out_red, want.out_green, want.out_blue} = src_pix[addr];
                want.out_alpha = nnsb_pkg::ALPHA_OPAQUE;
                want.covered   = 1'b1;
            end else begin
                want.out_red   = beat.in_red;
                want.out_green = beat.in_green;
                want.out_blue  = beat.in_blue;
                want.out_alpha = beat.in_alpha;
                want.covered   = 1'b0;
            end
            pixel_q.insert(pixel_q.size(), want);
        end
        beats_sent++;
    endtask

    task automatic send_beat(input nnsb_pkg::t_in_beat beat);
        int gap;
        gap = (source_steady || $urandom_range(1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= beat;
        do @(posedge i_clk); while (!in_if.ready);
        record_beat(beat);
    endtask

    task automatic load_pixel(input int x, input int y, input int r, input int g, input int b);
        nnsb_pkg::t_in_beat beat;
        beat.req_type = nnsb_pkg::REQ_LOAD;
        beat.pos_x    = POS_W'(x);
        beat.pos_y    = POS_W'(y);
        beat.in_red   = 8'(r);
        beat.in_green = 8'(g);
        beat.in_blue  = 8'(b);
        beat.in_alpha = 8'($urandom_range(255));
        send_beat(beat);
    endtask

    // fill the mapped store entry first if it was never loaded
    task automatic composite_pixel(input int x, input int y, input int r, input int g,
                                   input int b, input int a);
        nnsb_pkg::t_in_beat beat;
        int unsigned        addr;
        beat.req_type = nnsb_pkg::REQ_COMP;
        beat.pos_x    = POS_W'(x);
        beat.pos_y    = POS_W'(y);
        beat.in_red   = 8'(r);
        beat.in_green = 8'(g);
        beat.in_blue  = 8'(b);
        beat.in_alpha = 8'(a);
        if (locate_source(beat, addr) && !src_loaded[addr])
            load_pixel(addr % SRC_W_MAX, addr / SRC_W_MAX, $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
        send_beat(beat);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic cfg_write(input nnsb_pkg::t_cfg_idx idx, input logic [CFG_DW-1:0] word);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= word;
    endtask

    // upper bits above a register's width are don't-care; drive them random
    task automatic apply_config(input nnsb_pkg::t_cfg c);
        logic [CFG_DW-1:0] word;
        drain_results();
        word = CFG_DW'($urandom); word[8:0] = c.src_w;
        cfg_write(nnsb_pkg::CFG_SRC_W, word);
        word = CFG_DW'($urandom); word[8:0] = c.src_h;
        cfg_write(nnsb_pkg::CFG_SRC_H, word);
        word = CFG_DW'($urandom); word[POS_W-1:0] = c.canvas_c;
        cfg_write(nnsb_pkg::CFG_CANVAS_C, word);
        word = CFG_DW'($urandom); word[POS_W-1:0] = c.canvas_r;
        cfg_write(nnsb_pkg::CFG_CANVAS_R, word);
        word = CFG_DW'($urandom); word[POS_W-1:0] = c.tgt_w;
        cfg_write(nnsb_pkg::CFG_TGT_W, word);
        word = CFG_DW'($urandom); word[POS_W-1:0] = c.tgt_h;
        cfg_write(nnsb_pkg::CFG_TGT_H, word);
        cfg_write(nnsb_pkg::CFG_OFF_X, c.off_x);
        cfg_write(nnsb_pkg::CFG_OFF_Y, c.off_y);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        blit_cfg = c;
    endtask

    function automatic nnsb_pkg::t_cfg make_cfg(input int sw, input int sh, input int cc,
                                                input int cr, input int tw, input int th,
                                                input int ox, input int oy);
        nnsb_pkg::t_cfg c;
        c.src_w    = 9'(sw);
        c.src_h    = 9'(sh);
        c.canvas_c = POS_W'(cc);
        c.canvas_r = POS_W'(cr);
        c.tgt_w    = POS_W'(tw);
        c.tgt_h    = POS_W'(th);
        c.off_x    = CFG_DW'(ox);
        c.off_y    = CFG_DW'(oy);
        return c;
    endfunction

    function automatic int rand_src_size();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 0;
        if (r < 8) return 256;
        if (r < 11) return $urandom_range(511, 257);
        if (r < 16) return $urandom_range(255, 21);
        return $urandom_range(20, 1);
    endfunction

    function automatic int rand_extent();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 0;
        if (r < 10) return 4095;
        if (r < 45) return $urandom_range(64, 1);
        return $urandom_range(1024, 65);
    endfunction

    function automatic int rand_offset();
        int r;
        r = $urandom_range(99);
        if (r < 3) return -4095;
        if (r < 6) return 4095;
        if (r < 8) return -4096;
        if (r < 25) return $urandom_range(4095, 0) - $urandom_range(4096, 0);
        return $urandom_range(664, 0) - 64;
    endfunction

    function automatic nnsb_pkg::t_cfg random_cfg();
        int tw;
        int th;
        tw = rand_extent();
        th = rand_extent();
        return make_cfg(rand_src_size(), rand_src_size(),
                        ($urandom_range(9) == 0) ? rand_extent() : 4095 - $urandom_range(3000),
                        ($urandom_range(9) == 0) ? rand_extent() : 4095 - $urandom_range(3000),
                        tw, th, rand_offset(), rand_offset());
    endfunction

    function automatic int pick_coord(input logic signed [CFG_DW-1:0] off,
                                      input logic [POS_W-1:0] dst);
        int r;
        int lo;
        int hi;
        r = $urandom_range(99);
        if (r < 4) return 0;
        if (r < 8) return 4095;
        if (r < 25) return $urandom_range(4095);
        lo = off;
        lo = lo - 2;
        hi = lo + dst + 4;
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        if (hi < lo) return $urandom_range(4095);
        return $urandom_range(hi, lo);
    endfunction

    task automatic test_reset_settings();
        composite_pixel(0, 0, 8'h12, 8'h34, 8'h56, 8'h00);
        composite_pixel(639, 479, 8'h00, 8'h00, 8'h00, 8'h00);
        composite_pixel(640, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        composite_pixel(0, 480, 8'hA5, 8'h5A, 8'h0F, 8'h80);
        composite_pixel(4095, 4095, 8'h01, 8'h02, 8'h03, 8'h04);
    endtask

    task automatic test_load_outside_store();
        load_pixel(256, 0, 8'hFF, 8'hFF, 8'hFF);
        load_pixel(0, 4095, 8'hFF, 8'hFF, 8'hFF);
        load_pixel(4095, 4095, 8'h00, 8'h00, 8'h00);
        load_pixel(255, 255, 8'hFF, 8'h00, 8'hFF);
        composite_pixel(639, 479, 8'h00, 8'hFF, 8'h00, 8'h7F);
    endtask

    task automatic test_source_size_clamps();
        apply_config(make_cfg(0, 511, 4095, 4095, 4095, 4095, 0, 0));
        composite_pixel(4094, 4094, 8'h11, 8'h22, 8'h33, 8'h44);
        composite_pixel(0, 0, 8'h55, 8'h66, 8'h77, 8'h88);
        apply_config(make_cfg(300, 1, 4095, 4095, 1, 4095, 0, 0));
        composite_pixel(0, 4094, 8'h99, 8'hAA, 8'hBB, 8'hCC);
        composite_pixel(1, 4094, 8'h99, 8'hAA, 8'hBB, 8'hCC);
    endtask

    task automatic test_empty_regions();
        apply_config(make_cfg(4, 4, 0, 16, 16, 16, 0, 0));
        composite_pixel(3, 3, 8'hDE, 8'hAD, 8'hBE, 8'hEF);
        apply_config(make_cfg(4, 4, 16, 16, 16, 0, 0, 0));
        composite_pixel(3, 3, 8'hCA, 8'hFE, 8'hF0, 8'h0D);
    endtask

    task automatic test_offset_extremes();
        apply_config(make_cfg(8, 8, 4095, 4095, 4095, 4095, -4000, 4094));
        composite_pixel(94, 4094, 8'h10, 8'h20, 8'h30, 8'h40);
        composite_pixel(95, 4094, 8'h10, 8'h20, 8'h30, 8'h40);
        apply_config(make_cfg(8, 8, 4095, 4095, 4095, 4095, -4096, 4095));
        composite_pixel(4094, 4094, 8'hFE, 8'hDC, 8'hBA, 8'h98);
        apply_config(make_cfg(16, 16, 100, 100, 10, 10, -1, -1));
        composite_pixel(0, 0, 8'h00, 8'h00, 8'h00, 8'hFF);
        composite_pixel(8, 8, 8'h00, 8'h00, 8'h00, 8'hFF);
        composite_pixel(9, 9, 8'h00, 8'h00, 8'h00, 8'hFF);
    endtask

    task automatic run_random_phase();
        int n;
        int r;
        apply_config(random_cfg());
        sink_steady   = ($urandom_range(3) == 0);
        source_steady = ($urandom_range(3) == 0);
        n = $urandom_range(140, 40);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 3)
                load_pixel($urandom_range(4095), $urandom_range(4095, 256), $urandom_range(255),
                           $urandom_range(255), $urandom_range(255));
            else if (r < 20)
                load_pixel($urandom_range(clamp_src(blit_cfg.src_w, SRC_W_MAX) - 1),
                           $urandom_range(clamp_src(blit_cfg.src_h, SRC_H_MAX) - 1),
                           $urandom_range(255), $urandom_range(255), $urandom_range(255));
            else
                composite_pixel(pick_coord(blit_cfg.off_x, blit_cfg.tgt_w),
                                pick_coord(blit_cfg.off_y, blit_cfg.tgt_h),
                                $urandom_range(255), $urandom_range(255),
                                $urandom_range(255), $urandom_range(255));
        end
    endtask

    task automatic test_random_traffic();
        while (beats_sent < ITEM_GOAL) run_random_phase();
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= 1'b1;
            if (!sink_steady && $urandom_range(99) < 25) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin : check_results
        nnsb_pkg::t_out_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch("result beat with no pending composite");
            end else begin
                want = pixel_q.pop_front();
                check_field("out_red", out_if.data.out_red, want.out_red);
                check_field("out_green", out_if.data.out_green, want.out_green);
                check_field("out_blue", out_if.data.out_blue, want.out_blue);
                check_field("out_alpha", out_if.data.out_alpha, want.out_alpha);
                check_field("covered", out_if.data.covered, want.covered);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = nnsb_pkg::CFG_SRC_W;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.data    = '0;
        out_if.ready  = 1'b0;
        mismatches    = 0;
        beats_sent    = 0;
        cycle_count   = 0;
        stall_left    = 0;
        sink_steady   = 1'b0;
        source_steady = 1'b0;
        blit_cfg      = make_cfg(nnsb_pkg::RST_SRC_W, nnsb_pkg::RST_SRC_H,
                                 nnsb_pkg::RST_CANVAS_C, nnsb_pkg::RST_CANVAS_R,
                                 nnsb_pkg::RST_TGT_W, nnsb_pkg::RST_TGT_H, 0, 0);
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_load_outside_store();
        test_source_size_clamps();
        test_empty_regions();
        test_offset_extremes();
        test_random_traffic();

        drain_results();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
